// ----- rtl/b64sc_pkg.sv -----
// Base64 stream codec package: shared constants, the command item type
// passed from front to back, and the alphabet mapping functions.
// No dependencies.
`timescale 1ns / 1ps

package b64sc_pkg;

    // direction register values
    localparam logic DIR_ENCODE = 1'b0;
    localparam logic DIR_DECODE = 1'b1;

    localparam logic [7:0] PAD_CHAR = 8'h3D;

    // default depth of the command queue between front and back
    localparam int B64SC_QUEUE_DEPTH = 2;

    // one command: up to four result bytes, index of the final one, end of message
    typedef struct packed {
        logic [3:0][7:0] bytes;
        logic [1:0]      last_idx;
        logic            last;
    } b64sc_cmd_t;

    // sextet to alphabet character
    function automatic logic [7:0] enc_char(input logic [5:0] v);
        logic [7:0] r;
        begin
            if (v < 6'd26)
                r = 8'h41 + {2'b00, v};
            else if (v < 6'd52)
                r = 8'h61 + {2'b00, v - 6'd26};
            else if (v < 6'd62)
                r = 8'h30 + {2'b00, v - 6'd52};
            else if (v == 6'd62)
                r = 8'h2B;
            else
                r = 8'h2F;
            return r;
        end
    endfunction

    // character to sextet; unknown characters and padding give zero
    function automatic logic [5:0] sextet_of(input logic [7:0] c);
        logic [7:0] r;
        begin
            if (c >= 8'h41 && c <= 8'h5A)
                r = c - 8'h41;
            else if (c >= 8'h61 && c <= 8'h7A)
                r = c - 8'h61 + 8'd26;
            else if (c >= 8'h30 && c <= 8'h39)
                r = c - 8'h30 + 8'd52;
            else if (c == 8'h2B)
                r = 8'd62;
            else if (c == 8'h2F)
                r = 8'd63;
            else
                r = 8'd0;
            return r[5:0];
        end
    endfunction

endpackage

// ----- rtl/b64sc_front.sv -----
// Base64 codec front end: holds the direction register and the group
// accumulator, takes input items and turns each finished group, or the partial
// group that ends a message, into a command. Depends on b64sc_pkg.
`timescale 1ns / 1ps

module b64sc_front (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  logic               direction,
    input  logic               in_valid,
    output logic               in_stall,
    input  logic [7:0]         in_byte,
    input  logic               in_last,
    input  logic               q_full,
    output logic               q_push,
    output b64sc_pkg::b64sc_cmd_t q_cmd
);
    import b64sc_pkg::*;

    logic        dir_reg;
    logic [1:0]  pos_reg, pos_next;
    logic [23:0] acc_reg, acc_next;
    logic        pad_reg, pad_next;

    logic        accept;
    logic        produce;
    logic        is_pad;
    logic [5:0]  sext;
    logic [23:0] enc_acc;
    logic [23:0] dec_acc;
    b64sc_cmd_t  cmd;

    assign cfg_ready = 1'b1;
    assign in_stall  = q_full;
    assign accept    = in_valid && !q_full;

    assign is_pad  = (in_byte == PAD_CHAR);
    assign sext    = sextet_of(in_byte);
    assign enc_acc = {acc_reg[15:0], in_byte};
    assign dec_acc = {acc_reg[17:0], sext};

    // classify the item and build the command for a finished group
    always_comb
    begin
        produce  = 1'b0;
        cmd      = '0;
        cmd.last = in_last;
        pos_next = pos_reg + 2'd1;
        acc_next = acc_reg;
        pad_next = pad_reg;
        if (dir_reg == DIR_ENCODE)
        begin
            acc_next = enc_acc;
            cmd.last_idx = 2'd3;
            if (pos_reg == 2'd2)
            begin
                produce = 1'b1;
                cmd.bytes[0] = enc_char(enc_acc[23:18]);
                cmd.bytes[1] = enc_char(enc_acc[17:12]);
                cmd.bytes[2] = enc_char(enc_acc[11:6]);
                cmd.bytes[3] = enc_char(enc_acc[5:0]);
            end
            else if (in_last && pos_reg == 2'd0)
            begin
                produce = 1'b1;
                cmd.bytes[0] = enc_char(in_byte[7:2]);
                cmd.bytes[1] = enc_char({in_byte[1:0], 4'b0000});
                cmd.bytes[2] = PAD_CHAR;
                cmd.bytes[3] = PAD_CHAR;
            end
            else if (in_last)
            begin
                produce = 1'b1;
                cmd.bytes[0] = enc_char(enc_acc[15:10]);
                cmd.bytes[1] = enc_char(enc_acc[9:4]);
                cmd.bytes[2] = enc_char({enc_acc[3:0], 2'b00});
                cmd.bytes[3] = PAD_CHAR;
            end
        end
        else
        begin
            acc_next = dec_acc;
            pad_next = is_pad;
            if (pos_reg == 2'd3)
            begin
                produce = 1'b1;
                cmd.bytes[0] = dec_acc[23:16];
                cmd.bytes[1] = dec_acc[15:8];
                cmd.bytes[2] = dec_acc[7:0];
                if (in_last && is_pad)
                    cmd.last_idx = pad_reg ? 2'd0 : 2'd1;
                else
                    cmd.last_idx = 2'd2;
            end
            else if (in_last && pos_reg == 2'd0)
            begin
                // lone final character
                produce = 1'b1;
                cmd.bytes[0] = {sext, 2'b00};
                cmd.last_idx = 2'd0;
            end
            else if (in_last && pos_reg == 2'd1)
            begin
                produce = 1'b1;
                cmd.bytes[0] = dec_acc[11:4];
                cmd.last_idx = 2'd0;
            end
            else if (in_last)
            begin
                produce = 1'b1;
                cmd.bytes[0] = dec_acc[17:10];
                cmd.bytes[1] = dec_acc[9:2];
                cmd.last_idx = 2'd1;
            end
        end
        // a finished group or the end of a message starts a fresh group
        if (produce || in_last)
        begin
            pos_next = 2'd0;
            acc_next = '0;
            pad_next = 1'b0;
        end
    end

    assign q_push = accept && produce;
    assign q_cmd  = cmd;

    // direction register and group state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dir_reg <= DIR_ENCODE;
            pos_reg <= '0;
            acc_reg <= '0;
            pad_reg <= 1'b0;
        end
        else if (cfg_valid && cfg_ready)
        begin
            dir_reg <= direction;
            pos_reg <= '0;
            acc_reg <= '0;
            pad_reg <= 1'b0;
        end
        else if (accept)
        begin
            pos_reg <= pos_next;
            acc_reg <= acc_next;
            pad_reg <= pad_next;
        end
    end

endmodule

// ----- rtl/b64sc_queue.sv -----
// Base64 codec command queue: a small FIFO between front and back end.
// Depends on b64sc_pkg.
`timescale 1ns / 1ps

module b64sc_queue #(
    parameter int DEPTH = b64sc_pkg::B64SC_QUEUE_DEPTH
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  push,
    input  b64sc_pkg::b64sc_cmd_t wdata,
    input  logic                  pop,
    output b64sc_pkg::b64sc_cmd_t rdata,
    output logic                  full,
    output logic                  nonempty
);
    import b64sc_pkg::*;

    localparam int PW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);
    localparam logic [PW-1:0] PTR_MAX = PW'(DEPTH - 1);
    localparam logic [CW-1:0] CNT_FULL = CW'(DEPTH);

    b64sc_cmd_t    mem [DEPTH];
    logic [PW-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [CW-1:0] cnt_reg;

    assign full     = (cnt_reg == CNT_FULL);
    assign nonempty = (cnt_reg != '0);
    assign rdata    = mem[rd_ptr_reg];

    // storage
    always_ff @(posedge clk)
    begin
        if (push)
            mem[wr_ptr_reg] <= wdata;
    end

    // pointers and fill count
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            if (push)
                wr_ptr_reg <= (wr_ptr_reg == PTR_MAX) ? '0 : wr_ptr_reg + 1'b1;
            if (pop)
                rd_ptr_reg <= (rd_ptr_reg == PTR_MAX) ? '0 : rd_ptr_reg + 1'b1;
            if (push && !pop)
                cnt_reg <= cnt_reg + 1'b1;
            else if (pop && !push)
                cnt_reg <= cnt_reg - 1'b1;
        end
    end

endmodule

// ----- rtl/b64sc_back.sv -----
// Base64 codec back end: takes commands from the queue and sends their
// bytes out one item per cycle while out_stall is low. Depends on b64sc_pkg.
`timescale 1ns / 1ps

module b64sc_back (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  q_nonempty,
    input  b64sc_pkg::b64sc_cmd_t q_cmd,
    output logic                  q_pop,
    output logic                  out_valid,
    input  logic                  out_stall,
    output logic [7:0]            out_byte,
    output logic                  out_last
);
    import b64sc_pkg::*;

    b64sc_cmd_t cur_reg;
    logic       busy_reg;
    logic [1:0] idx_reg;
    logic       at_end;
    logic       finish;

    assign at_end    = (idx_reg == cur_reg.last_idx);
    assign finish    = busy_reg && !out_stall && at_end;
    assign q_pop     = q_nonempty && (!busy_reg || finish);

    assign out_valid = busy_reg;
    assign out_byte  = cur_reg.bytes[idx_reg];
    assign out_last  = cur_reg.last && at_end;

    // current command and byte index
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            idx_reg  <= '0;
            cur_reg  <= '0;
        end
        else if (q_pop)
        begin
            busy_reg <= 1'b1;
            idx_reg  <= '0;
            cur_reg  <= q_cmd;
        end
        else if (finish)
        begin
            busy_reg <= 1'b0;
        end
        else if (busy_reg && !out_stall)
        begin
            idx_reg <= idx_reg + 2'd1;
        end
    end

endmodule

// ----- rtl/base64_stream_codec_unit.sv -----
// Streaming Base64 codec (standard alphabet). direction = 0 encodes bytes to
// text, 1 decodes text to bytes. Input items are taken one per cycle while
// the command queue has room; results leave one per cycle from the back-end
// serializer while out_stall is low; encoding takes three bytes in per four
// characters out and decoding sustains one item per cycle. Writing direction
// discards any partial group. Depends on b64sc_pkg and the b64sc_* modules.
`timescale 1ns / 1ps

module base64_stream_codec_unit #(
    parameter int QUEUE_DEPTH = b64sc_pkg::B64SC_QUEUE_DEPTH
) (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       cfg_valid,
    output logic       cfg_ready,
    input  logic       direction,
    input  logic       in_valid,
    output logic       in_stall,
    input  logic [7:0] in_byte,
    input  logic       in_last,
    output logic       out_valid,
    input  logic       out_stall,
    output logic [7:0] out_byte,
    output logic       out_last
);
    import b64sc_pkg::*;

    b64sc_cmd_t push_cmd;
    b64sc_cmd_t head_cmd;
    logic       q_push;
    logic       q_pop;
    logic       q_full;
    logic       q_nonempty;

    b64sc_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .direction (direction),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_byte   (in_byte),
        .in_last   (in_last),
        .q_full    (q_full),
        .q_push    (q_push),
        .q_cmd     (push_cmd)
    );

    b64sc_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (q_push),
        .wdata    (push_cmd),
        .pop      (q_pop),
        .rdata    (head_cmd),
        .full     (q_full),
        .nonempty (q_nonempty)
    );

    b64sc_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .q_nonempty (q_nonempty),
        .q_cmd      (head_cmd),
        .q_pop      (q_pop),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .out_byte   (out_byte),
        .out_last   (out_last)
    );

endmodule

// ----- rtl/b64sc_checker.sv -----
// Port-level checks for the Base64 stream codec, bound to the top level.
// Depends on base64_stream_codec_unit.
`timescale 1ns / 1ps

module b64sc_checker (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       cfg_ready,
    input  logic       in_valid,
    input  logic       in_stall,
    input  logic       out_valid,
    input  logic       out_stall,
    input  logic [7:0] out_byte,
    input  logic       out_last
);

    // a stalled result holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(out_byte) && $stable(out_last))
        else $error("stalled result changed");

    // leaving reset the block is empty and open
    a_reset_idle: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(rst_n) |-> !out_valid && !in_stall)
        else $error("block not idle after reset");

    // configuration is always taken
    a_cfg_ready: assert property (@(posedge clk) disable iff (!rst_n)
        cfg_ready)
        else $error("configuration port not ready");

    // the queue only fills by taking an item
    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(in_stall) |-> $past(in_valid && !in_stall))
        else $error("input stall without a preceding item");

endmodule

bind base64_stream_codec_unit b64sc_checker u_b64sc_checker (.*);
